// ===== hdl/crtoi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crtoi_pkg
// Shared types, constants and helpers of the radix text to integer converter.
// ----------------------------------------------------------------------------
package crtoi_pkg;

   localparam int MAX_RADIX    = 16;
   localparam int STORED_CHARS = 16;
   localparam int LEN_W        = 5;
   localparam int DIGIT_W      = 4;
   localparam int VALUE_W      = 32;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 2;

   // effective radix cap: the smaller of the radix limit and the stored characters
   localparam logic [LEN_W-1:0] ALPHA_LIMIT =
      LEN_W'((MAX_RADIX < STORED_CHARS) ? MAX_RADIX : STORED_CHARS);

   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_CHARS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_CHARS = 2'd2;

   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] SPACE_LO   = 8'd9;
   localparam logic [7:0] SPACE_HI   = 8'd13;
   localparam logic [7:0] SPACE_CHAR = 8'd32;

   typedef logic [7:0] char_type;
   typedef logic [STORED_CHARS-1:0][7:0] alphabet_type;

   typedef struct packed {
      logic [LEN_W-1:0] length;
      logic             valid;
   } alpha_info_type;

   typedef struct packed {
      logic               hit;
      logic [DIGIT_W-1:0] index;
   } digit_match_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               alpha_valid;
   } result_type;

   function automatic logic is_space(input char_type c);
      return c inside {[SPACE_LO:SPACE_HI], SPACE_CHAR};
   endfunction

endpackage

// ===== hdl/crtoi_alphabet.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crtoi_alphabet
// Alphabet decode: effective length, validity check and parallel digit match.
// ----------------------------------------------------------------------------
module crtoi_alphabet (
   input  logic [crtoi_pkg::LEN_W-1:0] length_in,
   input  crtoi_pkg::alphabet_type     chars,
   input  crtoi_pkg::char_type         char_in,
   output crtoi_pkg::alpha_info_type   info,
   output crtoi_pkg::digit_match_type  match
);

   logic [crtoi_pkg::LEN_W-1:0] limit;
   logic [crtoi_pkg::LEN_W-1:0] eff_len;

   assign limit = (length_in > crtoi_pkg::ALPHA_LIMIT) ? crtoi_pkg::ALPHA_LIMIT : length_in;

   // a zero byte cuts the alphabet short
   always_comb begin
      eff_len = limit;
      for (int k = crtoi_pkg::STORED_CHARS - 1; k >= 0; k--) begin
         if (crtoi_pkg::LEN_W'(k) < limit && chars[k] == crtoi_pkg::CHAR_NUL) begin
            eff_len = crtoi_pkg::LEN_W'(k);
         end
      end
   end

   always_comb begin
      logic ok;
      ok = (eff_len >= crtoi_pkg::LEN_W'(2));
      for (int i = 0; i < crtoi_pkg::STORED_CHARS; i++) begin
         if (crtoi_pkg::LEN_W'(i) < eff_len) begin
            if (chars[i] == crtoi_pkg::CHAR_PLUS || chars[i] == crtoi_pkg::CHAR_MINUS ||
                crtoi_pkg::is_space(chars[i])) begin
               ok = 1'b0;
            end
            for (int j = i + 1; j < crtoi_pkg::STORED_CHARS; j++) begin
               if (crtoi_pkg::LEN_W'(j) < eff_len && chars[j] == chars[i]) begin
                  ok = 1'b0;
               end
            end
         end
      end
      info.length = eff_len;
      info.valid  = ok;
   end

   // lowest matching position wins
   always_comb begin
      match.hit   = 1'b0;
      match.index = '0;
      for (int k = crtoi_pkg::STORED_CHARS - 1; k >= 0; k--) begin
         if (crtoi_pkg::LEN_W'(k) < eff_len && chars[k] == char_in) begin
            match.hit   = 1'b1;
            match.index = crtoi_pkg::DIGIT_W'(k);
         end
      end
   end

endmodule

// ===== hdl/crtoi_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crtoi_parser
// Per-string parse state: whitespace skip, sign fold and digit accumulation.
// ----------------------------------------------------------------------------
module crtoi_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  crtoi_pkg::char_type         char_in,
   input  logic                        last,
   input  crtoi_pkg::alpha_info_type   info,
   input  crtoi_pkg::digit_match_type  match,
   output crtoi_pkg::result_type       result
);

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGN,
      PH_DIGITS,
      PH_DONE
   } parse_phase_type;

   parse_phase_type                 phase_ff, phase_in;
   logic                            neg_ff, neg_in;
   logic [crtoi_pkg::VALUE_W-1:0]   acc_ff, acc_in;
   logic [crtoi_pkg::VALUE_W-1:0]   product;

   assign product = acc_ff * {{(crtoi_pkg::VALUE_W - crtoi_pkg::LEN_W){1'b0}}, info.length};

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      if (char_in == crtoi_pkg::CHAR_NUL) begin
         phase_in = PH_DONE;
      end
      if (phase_in == PH_SPACE && !crtoi_pkg::is_space(char_in)) begin
         phase_in = PH_SIGN;
      end
      if (phase_in == PH_SIGN) begin
         if (char_in == crtoi_pkg::CHAR_MINUS) begin
            neg_in = ~neg_ff;
         end else if (char_in != crtoi_pkg::CHAR_PLUS) begin
            phase_in = PH_DIGITS;
         end
      end
      if (phase_in == PH_DIGITS) begin
         if (!match.hit) begin
            phase_in = PH_DONE;
         end else begin
            acc_in = product
                     + {{(crtoi_pkg::VALUE_W - crtoi_pkg::DIGIT_W){1'b0}}, match.index};
         end
      end
   end

   always_comb begin
      result.alpha_valid = info.valid;
      if (!info.valid) begin
         result.value = '0;
      end else if (neg_in) begin
         result.value = '0 - acc_in;
      end else begin
         result.value = acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
      end else if (step) begin
         if (last) begin
            phase_ff <= PH_SPACE;
            neg_ff   <= 1'b0;
            acc_ff   <= '0;
         end else begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            acc_ff   <= acc_in;
         end
      end
   end

endmodule

// ===== hdl/custom_radix_text_to_int.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// custom_radix_text_to_int
// Text to signed integer conversion in a radix set by a configured alphabet.
// ----------------------------------------------------------------------------
// the result is registered and appears in the cycle after the accepted beat marked end_of_string
// throughput: one beat per cycle while req_stall is low, set by the accumulator multiply-add loop
// a result held by rsp_stall stalls the input until it is taken
// reset: synchronous, clears the alphabet registers, parse state and rsp_valid
module custom_radix_text_to_int (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_char_in,
   input  logic                              req_end_of_string,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [crtoi_pkg::VALUE_W-1:0] rsp_value_out,
   output logic                              rsp_alphabet_valid,
   input  logic                              csr_write_enable,
   input  logic [crtoi_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [crtoi_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   logic [crtoi_pkg::LEN_W-1:0]      length_ff;
   logic [crtoi_pkg::CSR_DATA_W-1:0] low_chars_ff;
   logic [crtoi_pkg::CSR_DATA_W-1:0] high_chars_ff;

   crtoi_pkg::alphabet_type    chars;
   crtoi_pkg::alpha_info_type  info;
   crtoi_pkg::digit_match_type match;
   crtoi_pkg::result_type      result;

   logic                          rsp_valid_ff;
   logic [crtoi_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                          rsp_alpha_ff;
   logic                          req_accept;

   assign chars      = {high_chars_ff, low_chars_ff};
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff     <= '0;
         low_chars_ff  <= '0;
         high_chars_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            crtoi_pkg::CSR_LENGTH:     length_ff     <= csr_write_data[crtoi_pkg::LEN_W-1:0];
            crtoi_pkg::CSR_LOW_CHARS:  low_chars_ff  <= csr_write_data;
            crtoi_pkg::CSR_HIGH_CHARS: high_chars_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   crtoi_alphabet u_alphabet (
      .length_in (length_ff),
      .chars     (chars),
      .char_in   (req_char_in),
      .info      (info),
      .match     (match)
   );

   crtoi_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (req_accept),
      .char_in (req_char_in),
      .last    (req_end_of_string),
      .info    (info),
      .match   (match),
      .result  (result)
   );

   // result register, loaded on the last beat of a string
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= req_end_of_string;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (req_accept && req_end_of_string) begin
         rsp_value_ff <= result.value;
         rsp_alpha_ff <= result.alpha_valid;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value_out      = rsp_value_ff;
   assign rsp_alphabet_valid = rsp_alpha_ff;

`ifndef SYNTH
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_end_of_string |=> rsp_valid)
      else $error("no result after the last beat of a string");

   a_mid_beat_no_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_end_of_string |=> !rsp_valid)
      else $error("result raised by a beat that does not end a string");

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_alphabet_valid |-> rsp_value_out == '0)
      else $error("non-zero value with an invalid alphabet");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while the result register can drain");
`endif

endmodule
